>>> design/assert_macros.svh
// Assertion macros shared by the LCD write sequencer RTL.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/clw_pkg.sv
// Package for the character LCD write sequencer: request codes, LCD bytes,
// sizes and the structs shared by the top level and the BCD pipeline.
// Depends on nothing.
package clw_pkg;

    typedef enum logic [2:0] {
        CMD_RAW    = 3'd0,
        CMD_CHAR   = 3'd1,
        CMD_SETPOS = 3'd2,
        CMD_NUM    = 3'd3,
        CMD_NUMPOS = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_INIT   = 3'd6
    } cmd_t;

    localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_DISP_CLEAR = 8'h01;
    localparam logic [7:0] LCD_ROW0_ADDR  = 8'h80;
    localparam logic [7:0] LCD_ROW1_ADDR  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO     = 8'd48;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam int DEF_NUMBER_BITS = 16;
    localparam int DEF_COLUMNS     = 16;

    localparam int NUM_W      = 16;
    localparam int DIGITS     = 5;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int FIXED_MAX  = 5;
    localparam int MAX_WRITES = 6;
    localparam int WR_CNT_W   = $clog2(MAX_WRITES + 1);
    localparam int WR_IDX_W   = $clog2(MAX_WRITES);
    localparam int FIX_CNT_W  = $clog2(FIXED_MAX + 1);
    localparam int DD_STAGES  = 4;
    localparam int DD_STEPS   = NUM_W / DD_STAGES;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } lcd_write_t;

    typedef struct packed {
        logic                           with_num;
        logic [FIX_CNT_W-1:0]           n_fixed;
        lcd_write_t [FIXED_MAX-1:0]     fixed;
    } req_t;

endpackage

>>> design/clw_bcd_pipe.sv
// Stalling double-dabble pipeline that turns a 16-bit value into five BCD
// digits while carrying the decoded request alongside. Depends on clw_pkg.
module clw_bcd_pipe
    import clw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_req,
    input  logic [NUM_W-1:0] in_value,
    output logic             out_valid,
    input  logic             out_ready,
    output req_t             out_req,
    output logic [BCD_W-1:0] out_bcd
);

    localparam int WORK_W = BCD_W + NUM_W;

    function automatic logic [WORK_W-1:0] dd_step(input logic [WORK_W-1:0] w);
        logic [WORK_W-1:0] t;
        t = w;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (t[NUM_W + 4 * d +: 4] >= 4'd5)
            begin
                t[NUM_W + 4 * d +: 4] = t[NUM_W + 4 * d +: 4] + 4'd3;
            end
        end
        return t << 1;
    endfunction

    logic [DD_STAGES-1:0] valid_reg;
    logic [DD_STAGES-1:0] valid_next;
    req_t                 req_reg  [DD_STAGES];
    req_t                 req_next [DD_STAGES];
    logic [WORK_W-1:0]    work_reg [DD_STAGES];
    logic [WORK_W-1:0]    work_next[DD_STAGES];
    logic [DD_STAGES:0]   can_load;

    always_comb
    begin
        can_load[DD_STAGES] = out_ready;
        for (int i = DD_STAGES - 1; i >= 0; i--)
        begin
            can_load[i] = !valid_reg[i] || can_load[i + 1];
        end
    end

    always_comb
    begin
        logic [WORK_W-1:0] w;
        for (int i = 0; i < DD_STAGES; i++)
        begin
            if (i == 0)
            begin
                w             = {{BCD_W{1'b0}}, in_value};
                req_next[i]   = in_req;
                valid_next[i] = can_load[i] ? in_valid : valid_reg[i];
            end
            else
            begin
                w             = work_reg[i - 1];
                req_next[i]   = req_reg[i - 1];
                valid_next[i] = can_load[i] ? valid_reg[i - 1] : valid_reg[i];
            end
            for (int s = 0; s < DD_STEPS; s++)
            begin
                w = dd_step(w);
            end
            work_next[i] = w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DD_STAGES; i++)
        begin
            if (can_load[i])
            begin
                req_reg[i]  <= req_next[i];
                work_reg[i] <= work_next[i];
            end
        end
    end

    assign in_ready  = can_load[0];
    assign out_valid = valid_reg[DD_STAGES - 1];
    assign out_req   = req_reg[DD_STAGES - 1];
    assign out_bcd   = work_reg[DD_STAGES - 1][WORK_W-1 -: BCD_W];

endmodule

>>> design/char_lcd_write_sequencer.sv
// Top level of the character LCD write sequencer: request decode, BCD
// pipeline and the write emitter. Depends on clw_pkg, clw_bcd_pipe and
// assert_macros.svh.
//
// A request is taken at a rising edge where start is high and busy is low.
// Each request produces zero to six LCD bus writes. Every write sits on
// reg_select, bus_byte and last for exactly one cycle with strobe high;
// last marks the final write of the request. The receiver cannot stall.
// The request is decoded into a short list of fixed writes, then passes a
// four-stage binary-to-BCD pipeline, four shift steps per stage. The
// emitter then sends one write per cycle from its output registers.
// With the emitter idle, a request that is taken moves through the pipeline
// stage registers in order and then into the emitter's output registers,
// from which its first write drives the ports. A request holds the
// emitter until its last write is out, so the emitter sets the rate; busy
// rises when the pipeline behind it is full and the emitter cannot take its
// output. Requests that produce no write leave no trace.
// Reset empties the pipeline and the emitter; no write follows reset.
`include "assert_macros.svh"

module char_lcd_write_sequencer
    import clw_pkg::*;
#(
    parameter int NUMBER_BITS = DEF_NUMBER_BITS,
    parameter int COLUMNS     = DEF_COLUMNS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       cmd,
    input  logic [7:0]       byte_value,
    input  logic [1:0]       row,
    input  logic [4:0]       col,
    input  logic [NUM_W-1:0] number,
    output logic             strobe,
    output logic             reg_select,
    output logic [7:0]       bus_byte,
    output logic             last
);

    localparam int         VAL_BITS  = (NUMBER_BITS < NUM_W) ? NUMBER_BITS : NUM_W;
    localparam logic [4:0] COL_LIMIT = 5'(COLUMNS);

    req_t             dec_req;
    logic [NUM_W-1:0] masked;
    logic             pos_ok;
    logic [7:0]       pos_byte;
    logic             pipe_in_ready;
    logic             pipe_out_valid;
    req_t             pipe_req;
    logic [BCD_W-1:0] pipe_bcd;

    logic [2:0]                  ndig;
    lcd_write_t [DIGITS-1:0]     num_writes;
    lcd_write_t [MAX_WRITES-1:0] pack_list;
    logic [WR_CNT_W-1:0]         pack_cnt;

    logic                        em_valid_reg;
    logic                        em_valid_next;
    lcd_write_t [MAX_WRITES-1:0] em_list_reg;
    lcd_write_t [MAX_WRITES-1:0] em_list_next;
    logic [WR_CNT_W-1:0]         em_cnt_reg;
    logic [WR_CNT_W-1:0]         em_cnt_next;
    logic [WR_IDX_W-1:0]         em_idx_reg;
    logic [WR_IDX_W-1:0]         em_idx_next;
    logic                        em_at_last;
    logic                        em_free;

    always_comb
    begin
        for (int i = 0; i < NUM_W; i++)
        begin
            masked[i] = (i < VAL_BITS) ? number[i] : 1'b0;
        end
    end

    assign pos_ok   = (row <= 2'd1) && (col < COL_LIMIT);
    assign pos_byte = (row[0] ? LCD_ROW1_ADDR : LCD_ROW0_ADDR) | {4'b0000, col[3:0]};

    always_comb
    begin
        dec_req = '0;
        unique case (cmd_t'(cmd))
            CMD_RAW:
            begin
                dec_req.n_fixed  = FIX_CNT_W'(1);
                dec_req.fixed[0] = '{rs: RS_INSTR, data: byte_value};
            end
            CMD_CHAR:
            begin
                dec_req.n_fixed  = FIX_CNT_W'(1);
                dec_req.fixed[0] = '{rs: RS_DATA, data: byte_value};
            end
            CMD_SETPOS:
            begin
                dec_req.n_fixed  = pos_ok ? FIX_CNT_W'(1) : FIX_CNT_W'(0);
                dec_req.fixed[0] = '{rs: RS_INSTR, data: pos_byte};
            end
            CMD_NUM:
            begin
                dec_req.with_num = 1'b1;
            end
            CMD_NUMPOS:
            begin
                dec_req.with_num = pos_ok;
                dec_req.n_fixed  = pos_ok ? FIX_CNT_W'(1) : FIX_CNT_W'(0);
                dec_req.fixed[0] = '{rs: RS_INSTR, data: pos_byte};
            end
            CMD_CLEAR:
            begin
                dec_req.n_fixed  = FIX_CNT_W'(2);
                dec_req.fixed[0] = '{rs: RS_INSTR, data: LCD_DISP_CLEAR};
                dec_req.fixed[1] = '{rs: RS_INSTR, data: LCD_ROW0_ADDR};
            end
            CMD_INIT:
            begin
                dec_req.n_fixed  = FIX_CNT_W'(5);
                dec_req.fixed[0] = '{rs: RS_INSTR, data: LCD_FUNC_SET};
                dec_req.fixed[1] = '{rs: RS_INSTR, data: LCD_DISP_ON};
                dec_req.fixed[2] = '{rs: RS_INSTR, data: LCD_ENTRY_MODE};
                dec_req.fixed[3] = '{rs: RS_INSTR, data: LCD_DISP_CLEAR};
                dec_req.fixed[4] = '{rs: RS_INSTR, data: LCD_ROW0_ADDR};
            end
            default:
            begin
                dec_req = '0;
            end
        endcase
    end

    clw_bcd_pipe u_bcd_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_ready  (pipe_in_ready),
        .in_req    (dec_req),
        .in_value  (masked),
        .out_valid (pipe_out_valid),
        .out_ready (em_free),
        .out_req   (pipe_req),
        .out_bcd   (pipe_bcd)
    );

    assign busy = !pipe_in_ready;

    always_comb
    begin
        priority if (pipe_bcd[16 +: 4] != 4'd0) ndig = 3'd5;
        else if (pipe_bcd[12 +: 4] != 4'd0)     ndig = 3'd4;
        else if (pipe_bcd[8 +: 4] != 4'd0)      ndig = 3'd3;
        else if (pipe_bcd[4 +: 4] != 4'd0)      ndig = 3'd2;
        else                                     ndig = 3'd1;
    end

    always_comb
    begin
        logic [2:0] sel;
        logic [3:0] digit;
        for (int k = 0; k < DIGITS; k++)
        begin
            sel   = ndig - 3'(k) - 3'd1;
            digit = (3'(k) < ndig) ? pipe_bcd[4 * sel +: 4] : 4'd0;
            num_writes[k] = '{rs: RS_DATA, data: ASCII_ZERO + {4'b0000, digit}};
        end
    end

    always_comb
    begin
        pack_list = '0;
        if (pipe_req.with_num)
        begin
            if (pipe_req.n_fixed != '0)
            begin
                pack_list[0] = pipe_req.fixed[0];
                for (int k = 0; k < DIGITS; k++)
                begin
                    pack_list[k + 1] = num_writes[k];
                end
            end
            else
            begin
                for (int k = 0; k < DIGITS; k++)
                begin
                    pack_list[k] = num_writes[k];
                end
            end
            pack_cnt = WR_CNT_W'(pipe_req.n_fixed) + WR_CNT_W'(ndig);
        end
        else
        begin
            for (int k = 0; k < FIXED_MAX; k++)
            begin
                pack_list[k] = pipe_req.fixed[k];
            end
            pack_cnt = WR_CNT_W'(pipe_req.n_fixed);
        end
    end

    assign em_at_last = (WR_CNT_W'(em_idx_reg) == em_cnt_reg - WR_CNT_W'(1));
    assign em_free    = !em_valid_reg || em_at_last;

    always_comb
    begin
        em_valid_next = em_valid_reg;
        em_list_next  = em_list_reg;
        em_cnt_next   = em_cnt_reg;
        em_idx_next   = em_idx_reg;
        priority if (pipe_out_valid && em_free)
        begin
            em_valid_next = (pack_cnt != '0);
            em_list_next  = pack_list;
            em_cnt_next   = pack_cnt;
            em_idx_next   = '0;
        end
        else if (em_valid_reg && em_at_last)
        begin
            em_valid_next = 1'b0;
        end
        else if (em_valid_reg)
        begin
            em_idx_next = em_idx_reg + WR_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_cnt_reg   <= '0;
            em_idx_reg   <= '0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            em_cnt_reg   <= em_cnt_next;
            em_idx_reg   <= em_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        em_list_reg <= em_list_next;
    end

    assign strobe     = em_valid_reg;
    assign reg_select = em_list_reg[em_idx_reg].rs;
    assign bus_byte   = em_list_reg[em_idx_reg].data;
    assign last       = em_valid_reg && em_at_last;

    `ASSERT_NEXT(a_run_no_gap, clk, rst_n, strobe && !last, strobe, "write run broke off before last")
    `ASSERT_SAME(a_cnt_range, clk, rst_n, strobe, (em_cnt_reg != '0) && (em_cnt_reg <= WR_CNT_W'(MAX_WRITES)), "emitter count out of range")
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, strobe && last && !pipe_out_valid, !strobe, "write appeared without a request")
    `ASSERT_NEXT(a_idx_advance, clk, rst_n, strobe && !last, em_idx_reg == $past(em_idx_reg) + WR_IDX_W'(1), "write index skipped")

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for char_lcd_write_sequencer: directed requests from a table,
// then random requests under several sender gap rates, every bus write checked in order.
// Depends on clw_pkg and the char_lcd_write_sequencer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import clw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS = 20;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [8:0] NO_WR = 9'h000;

    typedef struct packed {
        lcd_write_t wr;
        logic       last;
    } bus_write_t;

    typedef struct packed {
        logic [2:0]      cmd;
        logic [7:0]      byte_value;
        logic [1:0]      row;
        logic [4:0]      col;
        logic [15:0]     number;
        logic            typed;
        logic [2:0]      n_typed;
        logic [5:0][8:0] w;
    } lcd_request_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [4:0] col;
    logic [15:0] number;
    logic strobe;
    logic reg_select;
    logic [7:0] bus_byte;
    logic last;

    logic cur_typed;
    logic [2:0] cur_n;
    logic [5:0][8:0] cur_w;

    bus_write_t lcd_writes_due[$];
    lcd_request_t directed_rows[$];
    bus_write_t exp_w;
    bus_write_t typed_w;
    int wi;
    int depth_at_transfer;
    int err_count = 0;
    int req_count = 0;
    int silent_count = 0;
    int productive_count = 0;
    int checked_writes = 0;
    int cycle_count = 0;

    char_lcd_write_sequencer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .number     (number),
        .strobe     (strobe),
        .reg_select (reg_select),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] expv,
                                   input logic [7:0] got);
        $display("MISMATCH at %0t ns: %s, expected %02h, got %02h", $time, what, expv, got);
        err_count++;
    endtask

    task automatic queue_lcd_writes(input logic [2:0] c, input logic [7:0] b,
                                    input logic [1:0] r, input logic [4:0] co,
                                    input logic [15:0] num);
        lcd_write_t run[$];
        logic with_num;
        logic pos_ok;
        logic [7:0] pos_byte;
        int v;
        int nd;
        int digits[5];
        bus_write_t bw;
        with_num = 1'b0;
        pos_ok = (r <= 2'd1) && (co < DEF_COLUMNS);
        pos_byte = ((r == 2'd0) ? LCD_ROW0_ADDR : LCD_ROW1_ADDR) | {4'h0, co[3:0]};
        case (c)
            CMD_RAW:    run.push_back('{RS_INSTR, b});
            CMD_CHAR:   run.push_back('{RS_DATA, b});
            CMD_SETPOS:
            begin
                if (pos_ok)
                    run.push_back('{RS_INSTR, pos_byte});
            end
            CMD_NUM:    with_num = 1'b1;
            CMD_NUMPOS:
            begin
                if (pos_ok)
                begin
                    run.push_back('{RS_INSTR, pos_byte});
                    with_num = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                run.push_back('{RS_INSTR, LCD_DISP_CLEAR});
                run.push_back('{RS_INSTR, LCD_ROW0_ADDR});
            end
            CMD_INIT:
            begin
                run.push_back('{RS_INSTR, LCD_FUNC_SET});
                run.push_back('{RS_INSTR, LCD_DISP_ON});
                run.push_back('{RS_INSTR, LCD_ENTRY_MODE});
                run.push_back('{RS_INSTR, LCD_DISP_CLEAR});
                run.push_back('{RS_INSTR, LCD_ROW0_ADDR});
            end
            default: ;
        endcase
        if (with_num)
        begin
            v = int'(num) & ((1 << DEF_NUMBER_BITS) - 1);
            nd = 0;
            do
            begin
                digits[nd] = v % 10;
                v = v / 10;
                nd++;
            end
            while (v != 0);
            for (int k = nd - 1; k >= 0; k--)
                run.push_back('{RS_DATA, ASCII_ZERO + 8'(digits[k])});
        end
        foreach (run[k])
        begin
            bw.wr = run[k];
            bw.last = (k == run.size() - 1);
            lcd_writes_due.push_back(bw);
        end
    endtask

    function automatic lcd_request_t mk(input logic [2:0] c, input logic [7:0] b,
                                        input logic [1:0] r, input logic [4:0] co,
                                        input logic [15:0] num, input logic typed,
                                        input logic [2:0] n, input logic [5:0][8:0] w);
        lcd_request_t q;
        q.cmd = c;
        q.byte_value = b;
        q.row = r;
        q.col = co;
        q.number = num;
        q.typed = typed;
        q.n_typed = n;
        q.w = w;
        return q;
    endfunction

    function automatic lcd_request_t random_request();
        lcd_request_t q;
        int p;
        q = '0;
        q.cmd = ($urandom_range(0, 99) < 5) ? CMD_UNUSED : 3'($urandom_range(0, 6));
        q.byte_value = 8'($urandom);
        if ($urandom_range(0, 99) < 85)
        begin
            q.row = 2'($urandom_range(0, 1));
            q.col = 5'($urandom_range(0, 15));
        end
        else
        begin
            q.row = 2'($urandom);
            q.col = 5'($urandom);
        end
        case ($urandom_range(0, 3))
            0: q.number = 16'($urandom);
            1: q.number = 16'($urandom_range(0, 99));
            2: q.number = 16'hFFFF - 16'($urandom_range(0, 3));
            default:
            begin
                p = 10 ** $urandom_range(0, 4);
                q.number = 16'(p - $urandom_range(0, 1));
            end
        endcase
        return q;
    endfunction

    task automatic send_request(input lcd_request_t q, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        cmd = q.cmd;
        byte_value = q.byte_value;
        row = q.row;
        col = q.col;
        number = q.number;
        cur_typed = q.typed;
        cur_n = q.n_typed;
        cur_w = q.w;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (lcd_writes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                depth_at_transfer = lcd_writes_due.size();
                if (cur_typed)
                begin
                    for (wi = 0; wi < cur_n; wi++)
                    begin
                        typed_w.wr = cur_w[5 - wi];
                        typed_w.last = (wi == cur_n - 1);
                        lcd_writes_due.push_back(typed_w);
                    end
                end
                else
                    queue_lcd_writes(cmd, byte_value, row, col, number);
                if (lcd_writes_due.size() == depth_at_transfer)
                    silent_count++;
                else
                    productive_count++;
                req_count++;
            end
            if (strobe)
            begin
                if (lcd_writes_due.size() == 0)
                    report_mismatch("write with nothing expected", 8'h00, bus_byte);
                else
                begin
                    exp_w = lcd_writes_due.pop_front();
                    if (reg_select !== exp_w.wr.rs)
                        report_mismatch("reg_select", 8'(exp_w.wr.rs), 8'(reg_select));
                    if (bus_byte !== exp_w.wr.data)
                        report_mismatch("bus_byte", exp_w.wr.data, bus_byte);
                    if (last !== exp_w.last)
                        report_mismatch("last", 8'(exp_w.last), 8'(last));
                    checked_writes++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int idle_pct[4];
        int target;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        byte_value = '0;
        row = '0;
        col = '0;
        number = '0;
        cur_typed = 1'b0;
        cur_n = '0;
        cur_w = '0;
        idle_pct = '{0, 50, 0, 6};

        directed_rows.push_back(mk(CMD_RAW, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_INSTR, 8'h00}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_RAW, 8'hFF, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_INSTR, 8'hFF}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_CHAR, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_DATA, 8'h00}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_CHAR, 8'hFF, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_DATA, 8'hFF}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_SETPOS, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_INSTR, LCD_ROW0_ADDR}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_SETPOS, 8'h00, 2'd1, 5'd15, 16'd0, 1'b1, 3'd1,
            {{RS_INSTR, 8'hCF}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_SETPOS, 8'h00, 2'd2, 5'd0, 16'd0, 1'b1, 3'd0,
            '0));
        directed_rows.push_back(mk(CMD_SETPOS, 8'hFF, 2'd3, 5'd31, 16'hFFFF, 1'b1, 3'd0,
            '0));
        directed_rows.push_back(mk(CMD_SETPOS, 8'h00, 2'd0, 5'd16, 16'd0, 1'b1, 3'd0,
            '0));
        directed_rows.push_back(mk(CMD_NUM, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd1,
            {{RS_DATA, ASCII_ZERO}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_NUM, 8'h00, 2'd0, 5'd0, 16'hFFFF, 1'b1, 3'd5,
            {{RS_DATA, 8'h36}, {RS_DATA, 8'h35}, {RS_DATA, 8'h35},
             {RS_DATA, 8'h33}, {RS_DATA, 8'h35}, NO_WR}));
        directed_rows.push_back(mk(CMD_NUM, 8'h00, 2'd0, 5'd0, 16'd9, 1'b1, 3'd1,
            {{RS_DATA, 8'h39}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_NUM, 8'h5A, 2'd3, 5'd31, 16'd10, 1'b0, 3'd0, '0));
        directed_rows.push_back(mk(CMD_NUMPOS, 8'h00, 2'd1, 5'd15, 16'hFFFF, 1'b1, 3'd6,
            {{RS_INSTR, 8'hCF}, {RS_DATA, 8'h36}, {RS_DATA, 8'h35},
             {RS_DATA, 8'h35}, {RS_DATA, 8'h33}, {RS_DATA, 8'h35}}));
        directed_rows.push_back(mk(CMD_NUMPOS, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd2,
            {{RS_INSTR, LCD_ROW0_ADDR}, {RS_DATA, ASCII_ZERO}, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_NUMPOS, 8'h00, 2'd3, 5'd5, 16'd123, 1'b1, 3'd0, '0));
        directed_rows.push_back(mk(CMD_NUMPOS, 8'h00, 2'd1, 5'd20, 16'd77, 1'b1, 3'd0, '0));
        directed_rows.push_back(mk(CMD_CLEAR, 8'hFF, 2'd3, 5'd31, 16'hFFFF, 1'b1, 3'd2,
            {{RS_INSTR, LCD_DISP_CLEAR}, {RS_INSTR, LCD_ROW0_ADDR},
             NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_INIT, 8'h00, 2'd0, 5'd0, 16'd0, 1'b1, 3'd5,
            {{RS_INSTR, LCD_FUNC_SET}, {RS_INSTR, LCD_DISP_ON}, {RS_INSTR, LCD_ENTRY_MODE},
             {RS_INSTR, LCD_DISP_CLEAR}, {RS_INSTR, LCD_ROW0_ADDR}, NO_WR}));
        directed_rows.push_back(mk(CMD_UNUSED, 8'hFF, 2'd1, 5'd3, 16'd42, 1'b1, 3'd0, '0));
        directed_rows.push_back(mk(CMD_CHAR, 8'h41, 2'd3, 5'd31, 16'hFFFF, 1'b1, 3'd1,
            {{RS_DATA, 8'h41}, NO_WR, NO_WR, NO_WR, NO_WR, NO_WR}));
        directed_rows.push_back(mk(CMD_NUM, 8'h00, 2'd0, 5'd0, 16'd12345, 1'b0, 3'd0, '0));
        directed_rows.push_back(mk(CMD_RAW, 8'hA5, 2'd2, 5'd17, 16'h5A5A, 1'b0, 3'd0, '0));
        directed_rows.push_back(mk(CMD_NUMPOS, 8'h00, 2'd0, 5'd7, 16'd1000, 1'b0, 3'd0, '0));
        directed_rows.push_back(mk(CMD_SETPOS, 8'hFF, 2'd1, 5'd10, 16'hFFFF, 1'b0, 3'd0, '0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            send_request(directed_rows[k], 0);
        start = 1'b0;
        wait_for_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            target = productive_count + PHASE_ITEMS;
            while (productive_count < target)
                send_request(random_request(), idle_pct[ph]);
            start = 1'b0;
            wait_for_drain();
        end

        if (lcd_writes_due.size() != 0)
            report_mismatch("writes never seen", 8'(lcd_writes_due.size()), 8'h00);

        $display("Sent %0d requests (%0d with no bus write: bad positions or unused code);",
                 req_count, silent_count);
        $display("checked %0d bus writes under sender gap rates of none, 50 and 6 percent.",
                 checked_writes);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
